/* rtl/core/crc8fr_pkg.sv */
// crc8 frame receiver shared types, constants and crc step function
`default_nettype none

package crc8fr_pkg;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ID      = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4
	} phase_t;

	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER_VALUE = 1'd0,
		CFG_STATUS_ID    = 1'd1
	} cfg_idx_t;

	localparam logic [7:0] HEADER_RESET    = 8'd170;
	localparam logic [7:0] STATUS_ID_RESET = 8'd1;
	localparam logic [5:0] STATUS_MIN_LEN  = 6'd4;

	localparam logic [7:0] CRC_TERMS [8] = '{
		8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
	};

	typedef struct packed {
		logic [7:0]  frame_id;
		logic [5:0]  frame_length;
		logic        status_seen;
		logic [15:0] morph_angle;
		logic [7:0]  peer_state;
		logic [7:0]  peer_error;
	} result_t;

	// reflected crc-8 maxim, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] sel;
		logic [7:0] acc;
		sel = crc ^ data;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (sel[k]) begin
				acc = acc ^ CRC_TERMS[k];
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/crc8fr_parser.sv */
// frame parser: phase machine, running crc and held frame fields
`default_nettype none

module crc8fr_parser import crc8fr_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] header_value,
	input  wire logic [7:0] status_id,
	output logic            res_valid,
	output result_t         res
);

	phase_t     phase_q, phase_d;
	logic [7:0] crc_q;
	logic [7:0] held_id_q;
	logic [5:0] held_length_q;
	logic [5:0] byte_index_q;
	logic [7:0] first_bytes_q [4];

	logic [7:0] crc_nxt;
	logic [5:0] idx_inc;
	logic       len_too_big;
	logic       status_hit;

	assign crc_nxt     = crc8_step(crc_q, rx_byte);
	assign idx_inc     = byte_index_q + 6'd1;
	assign len_too_big = rx_byte > 8'(MAX_PAYLOAD);

	always_comb begin
		unique case (phase_q)
			PH_HEADER:  phase_d = (rx_byte == header_value) ? PH_ID : PH_HEADER;
			PH_ID:      phase_d = PH_LEN;
			PH_LEN: begin
				if (len_too_big) begin
					phase_d = PH_HEADER;
				end else if (rx_byte == 8'd0) begin
					phase_d = PH_CRC;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: phase_d = (idx_inc == held_length_q) ? PH_CRC : PH_PAYLOAD;
			PH_CRC:     phase_d = PH_HEADER;
			default:    phase_d = PH_HEADER;
		endcase
	end

	always_comb begin
		status_hit = (held_id_q == status_id) && (held_length_q >= STATUS_MIN_LEN);
		res_valid  = take && (phase_q == PH_CRC) && (rx_byte == crc_q);
		res.frame_id     = held_id_q;
		res.frame_length = held_length_q;
		res.status_seen  = status_hit;
		res.morph_angle  = status_hit ? {first_bytes_q[1], first_bytes_q[0]} : 16'd0;
		res.peer_state   = status_hit ? first_bytes_q[2] : 8'd0;
		res.peer_error   = status_hit ? first_bytes_q[3] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			crc_q         <= '0;
			held_id_q     <= '0;
			held_length_q <= '0;
			byte_index_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_HEADER: begin
					if (rx_byte == header_value) begin
						crc_q <= '0;
					end
				end
				PH_ID: begin
					held_id_q <= rx_byte;
					crc_q     <= crc_nxt;
				end
				PH_LEN: begin
					if (!len_too_big) begin
						held_length_q <= rx_byte[5:0];
						crc_q         <= crc_nxt;
						byte_index_q  <= '0;
					end
				end
				PH_PAYLOAD: begin
					byte_index_q <= idx_inc;
					crc_q        <= crc_nxt;
				end
				default: begin
				end
			endcase
		end
	end

	// first four payload bytes
	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_PAYLOAD) && (byte_index_q < 6'd4)) begin
			first_bytes_q[byte_index_q[1:0]] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/crc8_frame_receiver_top.sv */
// crc8 frame receiver top level: config registers, parser and result register
//
// input channel: one received byte per item on rx_byte, in_valid / in_stall.
// frames are header, id, length, payload, crc (reflected crc-8 maxim over
// id, length and payload). a length above MAX_PAYLOAD drops the frame.
// output channel: one item per frame whose crc byte matches, carrying id,
// length and, for a status frame of at least four bytes, angle, state and
// error; out_valid / out_stall.
// latency: the result is valid in the cycle after the crc byte is taken.
// throughput: one byte per cycle while in_stall is low; the parser and crc
// step sit between the input and the result register.
// stall: in_stall rises only while a result waits and out_stall is high;
// the result holds steady until taken.
// reset: parser returns to header hunt, no result pending, header_value
// back to 170 and status_id to 1. config writes go in at once through
// cfg_wr_en, cfg_index (0 header value, 1 status id) and cfg_data.
`default_nettype none

module crc8_frame_receiver_top import crc8fr_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                frame_id,
	output logic [5:0]                frame_length,
	output logic                      status_seen,
	output logic [15:0]               morph_angle,
	output logic [7:0]                peer_state,
	output logic [7:0]                peer_error,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0] header_value_q;
	logic [7:0] status_id_q;
	logic       take;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q <= HEADER_RESET;
			status_id_q    <= STATUS_ID_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HEADER_VALUE: header_value_q <= cfg_data;
				CFG_STATUS_ID:    status_id_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	crc8fr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rx_byte      (rx_byte),
		.header_value (header_value_q),
		.status_id    (status_id_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_id     = out_q.frame_id;
	assign frame_length = out_q.frame_length;
	assign status_seen  = out_q.status_seen;
	assign morph_angle  = out_q.morph_angle;
	assign peer_state   = out_q.peer_state;
	assign peer_error   = out_q.peer_error;

endmodule

`default_nettype wire

/* rtl/core/crc8fr_checker.sv */
// port-level checks for the crc8 frame receiver and their bind
`default_nettype none

module crc8fr_checker import crc8fr_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  frame_id,
	input wire logic [5:0]  frame_length,
	input wire logic        status_seen,
	input wire logic [15:0] morph_angle,
	input wire logic [7:0]  peer_state,
	input wire logic [7:0]  peer_error
);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result appeared without an accepted item");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(frame_id)
			&& $stable(frame_length) && $stable(morph_angle)))
		else $error("stalled result changed");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_length <= 6'(MAX_PAYLOAD)
			&& (!status_seen || frame_length >= STATUS_MIN_LEN)))
		else $error("result length out of range");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status_seen) |-> (morph_angle == 16'd0 && peer_state == 8'd0
			&& peer_error == 8'd0))
		else $error("status fields set on a non-status result");

endmodule

bind crc8_frame_receiver_top crc8fr_checker #(
	.MAX_PAYLOAD(MAX_PAYLOAD)
) u_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// crc8 frame receiver testbench: directed frames, random framed streams, result checks
`timescale 1ns / 100ps

module testbench;
	import crc8fr_pkg::*;

	localparam int FRAME_MAX = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_BYTES = 285;

	typedef enum logic [1:0] {
		FEED_BYTE,
		FEED_CRC_GOOD,
		FEED_CRC_BAD
	} feed_kind_t;

	typedef struct packed {
		feed_kind_t  kind;
		logic [7:0]  value;
		logic        typed;
		logic        typed_hit;
		result_t     typed_res;
	} feed_row_t;

	localparam int DIRECTED_LEN = 27;

	localparam feed_row_t DIRECTED_FEED [DIRECTED_LEN] = '{
		// status frame, four bytes
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h01, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h04, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h34, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h12, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h07, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'hFF, 1'b0, 1'b0, '0},
		'{FEED_CRC_GOOD, 8'h00, 1'b1, 1'b1, '{8'h01, 6'd4, 1'b1, 16'h1234, 8'h07, 8'hFF}},
		// zero length, top id
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'hFF, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h00, 1'b0, 1'b0, '0},
		'{FEED_CRC_GOOD, 8'h00, 1'b1, 1'b1, '{8'hFF, 6'd0, 1'b0, 16'h0000, 8'h00, 8'h00}},
		// oversized length equal to header, then a frame that only exists if it were reparsed
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h01, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h00, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h00, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h00, 1'b1, 1'b0, '0},
		// short status frame
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h01, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h01, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h80, 1'b0, 1'b0, '0},
		'{FEED_CRC_GOOD, 8'h00, 1'b1, 1'b1, '{8'h01, 6'd1, 1'b0, 16'h0000, 8'h00, 8'h00}},
		// bad crc
		'{FEED_BYTE, 8'hAA, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h02, 1'b0, 1'b0, '0},
		'{FEED_BYTE, 8'h00, 1'b0, 1'b0, '0},
		'{FEED_CRC_BAD, 8'h00, 1'b1, 1'b0, '0}
	};

	localparam logic [7:0] PHASE_HEADER [PHASE_COUNT] = '{8'h00, 8'hFF, 8'h00, 8'hAA, 8'h7E, 8'h55};
	localparam logic [7:0] PHASE_STATUS [PHASE_COUNT] = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  frame_id;
	logic [5:0]  frame_length;
	logic        status_seen;
	logic [15:0] morph_angle;
	logic [7:0]  peer_state;
	logic [7:0]  peer_error;
	logic        cfg_wr_en = 1'b0;
	cfg_idx_t    cfg_index = CFG_HEADER_VALUE;
	logic [7:0]  cfg_data = 8'h00;

	// predictor state
	phase_t      rx_phase;
	logic [7:0]  crc_acc;
	logic [7:0]  id_hold;
	logic [5:0]  len_hold;
	logic [5:0]  pay_idx;
	logic [7:0]  pay_head [4];
	logic [7:0]  header_reg;
	logic [7:0]  status_reg;

	result_t     expected_frames [$];
	result_t     want_frame;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          frame_bytes = 0;
	int          stall_len;
	bit          sender_busy = 1'b1;
	bit          receiver_busy = 1'b1;

	crc8_frame_receiver_top #(.MAX_PAYLOAD(FRAME_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.status_seen(status_seen),
		.morph_angle(morph_angle),
		.peer_state(peer_state),
		.peer_error(peer_error),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// bitwise reflected crc-8, polynomial 0x31 reversed
	function automatic logic [7:0] crc8_maxim_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b, output bit hit, output result_t res);
		bit st;
		hit = 1'b0;
		res = '0;
		case (rx_phase)
			PH_ID: begin
				id_hold = b;
				crc_acc = crc8_maxim_update(crc_acc, b);
				rx_phase = PH_LEN;
			end
			PH_LEN: begin
				if (int'(b) > FRAME_MAX) begin
					rx_phase = PH_HEADER;
				end else begin
					len_hold = b[5:0];
					crc_acc = crc8_maxim_update(crc_acc, b);
					pay_idx = '0;
					rx_phase = (b == 8'h00) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pay_idx < 6'd4) begin
					pay_head[pay_idx[1:0]] = b;
				end
				pay_idx = pay_idx + 6'd1;
				crc_acc = crc8_maxim_update(crc_acc, b);
				if (pay_idx == len_hold) begin
					rx_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				if (b == crc_acc) begin
					st = (id_hold == status_reg) && (len_hold >= STATUS_MIN_LEN);
					hit = 1'b1;
					res.frame_id = id_hold;
					res.frame_length = len_hold;
					res.status_seen = st;
					res.morph_angle = st ? {pay_head[1], pay_head[0]} : 16'h0000;
					res.peer_state = st ? pay_head[2] : 8'h00;
					res.peer_error = st ? pay_head[3] : 8'h00;
				end
				rx_phase = PH_HEADER;
			end
			default: begin
				if (b == header_reg) begin
					rx_phase = PH_ID;
					crc_acc = 8'h00;
				end else begin
					rx_phase = PH_HEADER;
				end
			end
		endcase
	endfunction

	task automatic send_item(input logic [7:0] b, input bit typed, input bit typed_hit,
			input result_t typed_res);
		int gap;
		bit hit;
		result_t res;
		gap = sender_busy ? int'($urandom_range(0, 10)) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		parse_rx_byte(b, hit, res);
		if (typed) begin
			hit = typed_hit;
			res = typed_res;
		end
		if (hit) begin
			expected_frames.push_back(res);
		end
	endtask

	task automatic load_registers(input logic [7:0] hdr, input logic [7:0] sid);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_HEADER_VALUE;
		cfg_data <= hdr;
		@(negedge clk);
		cfg_index <= CFG_STATUS_ID;
		cfg_data <= sid;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		header_reg = hdr;
		status_reg = sid;
	endtask

	task automatic send_random_frame();
		int pick;
		int len;
		int cut;
		logic [7:0] id;
		logic [7:0] crc_byte;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		end
		send_item(header_reg, 1'b0, 1'b0, '0);
		id = ($urandom_range(0, 1) != 0) ? status_reg : 8'($urandom_range(0, 255));
		send_item(id, 1'b0, 1'b0, '0);
		pick = int'($urandom_range(0, 9));
		if (pick < 6) begin
			len = int'($urandom_range(0, 6));
		end else if (pick < 8) begin
			len = int'($urandom_range(7, FRAME_MAX));
		end else if (pick == 8) begin
			len = ($urandom_range(0, 1) != 0) ? FRAME_MAX : FRAME_MAX + 1;
		end else begin
			len = int'($urandom_range(FRAME_MAX + 1, 255));
		end
		send_item(8'(len), 1'b0, 1'b0, '0);
		frame_bytes += 3;
		if (len > FRAME_MAX) begin
			return;
		end
		// occasionally cut the frame short
		cut = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, len)) : -1;
		for (int n = 0; n < len; n++) begin
			if (n == cut) begin
				return;
			end
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
			frame_bytes++;
		end
		if (cut == len) begin
			return;
		end
		pick = int'($urandom_range(0, 9));
		if (pick < 8) begin
			crc_byte = crc_acc;
		end else if (pick == 8) begin
			crc_byte = crc_acc ^ (8'h01 << $urandom_range(0, 7));
		end else begin
			crc_byte = 8'($urandom_range(0, 255));
		end
		send_item(crc_byte, 1'b0, 1'b0, '0);
		frame_bytes++;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$error("unexpected frame: frame_id 0x%0h, frame_length %0d", frame_id, frame_length);
				mismatches++;
			end else begin
				want_frame = expected_frames.pop_front();
				check_field("frame_id", want_frame.frame_id, frame_id);
				check_field("frame_length", want_frame.frame_length, frame_length);
				check_field("status_seen", want_frame.status_seen, status_seen);
				check_field("morph_angle", want_frame.morph_angle, morph_angle);
				check_field("peer_state", want_frame.peer_state, peer_state);
				check_field("peer_error", want_frame.peer_error, peer_error);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			stall_len = receiver_busy ? int'($urandom_range(0, 10)) : 0;
			repeat (stall_len) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin : stimulus
		feed_row_t row;
		logic [7:0] b;
		logic [7:0] hdr;
		logic [7:0] sid;
		rx_phase = PH_HEADER;
		crc_acc = 8'h00;
		id_hold = 8'h00;
		len_hold = 6'd0;
		pay_idx = 6'd0;
		for (int k = 0; k < 4; k++) begin
			pay_head[k] = 8'h00;
		end
		header_reg = HEADER_RESET;
		status_reg = STATUS_ID_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_LEN; i++) begin
			row = DIRECTED_FEED[i];
			case (row.kind)
				FEED_CRC_GOOD: b = crc_acc;
				FEED_CRC_BAD: b = crc_acc ^ 8'h01;
				default: b = row.value;
			endcase
			send_item(b, row.typed, row.typed_hit, row.typed_res);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			hdr = (p == 2) ? 8'($urandom_range(0, 255)) : PHASE_HEADER[p];
			sid = (p == 2) ? 8'($urandom_range(0, 255)) : PHASE_STATUS[p];
			load_registers(hdr, sid);
			sender_busy = (p % 3) != 1;
			receiver_busy = (p % 2) == 0;
			frame_bytes = 0;
			while (frame_bytes < PHASE_BYTES) begin
				send_random_frame();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
